// File: hw/rtl/rr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rr_pkg
// Shared types and constants for the rational reduction core: controller
// states, datapath commands and the status word returned to the controller.
// ----------------------------------------------------------------------------
package rr_pkg;

    // width of the numerator and denominator ports
    localparam int FIELD_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_TWOS,
        ST_AEVEN,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HALVE_BOTH,
        OP_HALVE_A,
        OP_GCD,
        OP_DIV_INIT_N,
        OP_DIV_INIT_D,
        OP_DIV_STEP,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_UNDEF,
        KIND_ZERO
    } kind_t;

    typedef struct packed {
        op_t   op;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic d_zero;
        logic both_even;
        logic a_even;
        logic b_zero;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/rr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rr_ctrl
// Sequencer for the rational reduction core: steps the datapath through
// classification, binary gcd, two exact divisions and the result write.
// ----------------------------------------------------------------------------
module rr_ctrl
    import rr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    kind_t  kind_reg;
    kind_t  kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_NORMAL;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd.op     = OP_NONE;
        cmd.kind   = kind_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (status.d_zero) begin
                    kind_next  = KIND_UNDEF;
                    state_next = ST_EMIT;
                end else if (status.n_zero) begin
                    kind_next  = KIND_ZERO;
                    state_next = ST_EMIT;
                end else begin
                    kind_next  = KIND_NORMAL;
                    state_next = ST_TWOS;
                end
            end
            ST_TWOS: begin
                // strip common factors of two
                if (status.both_even) begin
                    cmd.op = OP_HALVE_BOTH;
                end else begin
                    state_next = ST_AEVEN;
                end
            end
            ST_AEVEN: begin
                if (status.a_even) begin
                    cmd.op = OP_HALVE_A;
                end else begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (status.b_zero) begin
                    cmd.op     = OP_DIV_INIT_N;
                    state_next = ST_DIVN;
                end else begin
                    cmd.op = OP_GCD;
                end
            end
            ST_DIVN: begin
                if (status.div_last) begin
                    cmd.op     = OP_DIV_INIT_D;
                    state_next = ST_DIVD;
                end else begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            ST_DIVD: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last) begin
                    cmd.op     = OP_NONE;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/rr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rr_datapath
// Magnitudes, binary gcd registers, a shared restoring divider and the
// output register of the rational reduction core.
// ----------------------------------------------------------------------------
module rr_datapath
    import rr_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic signed [FIELD_W-1:0] s_numer_in,
    input  logic signed [FIELD_W-1:0] s_denom_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [FIELD_W-1:0] m_numer_out,
    output logic signed [FIELD_W-1:0] m_denom_out,
    output logic                      m_undefined_flag,
    output logic                      m_overflow_flag
);

    localparam int SW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [WIDTH-1:0] HALF  = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] ONE_W = WIDTH'(1);

    logic [WIDTH-1:0] n_w;
    logic [WIDTH-1:0] d_w;

    // inputs sign-extended or truncated to the working width
    if (WIDTH > FIELD_W) begin : g_in_ext
        assign n_w = {{(WIDTH-FIELD_W){s_numer_in[FIELD_W-1]}}, s_numer_in};
        assign d_w = {{(WIDTH-FIELD_W){s_denom_in[FIELD_W-1]}}, s_denom_in};
    end else begin : g_in_cut
        assign n_w = s_numer_in[WIDTH-1:0];
        assign d_w = s_denom_in[WIDTH-1:0];
    end

    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [SW-1:0]    sh_reg, sh_next;
    logic [WIDTH-1:0] mag_n_reg, mag_n_next;
    logic [WIDTH-1:0] mag_d_reg, mag_d_next;
    logic             nneg_reg, nneg_next;
    logic             dneg_reg, dneg_next;
    logic             n_zero_reg, n_zero_next;
    logic             d_zero_reg, d_zero_next;
    logic [WIDTH-1:0] dv_reg, dv_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] mn_reg, mn_next;

    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] out_numer_reg, out_numer_next;
    logic [FIELD_W-1:0] out_denom_reg, out_denom_next;
    logic               out_undef_reg, out_undef_next;
    logic               out_ovf_reg, out_ovf_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   trial_sub;
    logic [WIDTH-1:0] diff_ab;
    logic [WIDTH-1:0] diff_ba;
    logic             a_gt_b;
    logic             nneg_in;
    logic             dneg_in;
    logic             neg;
    logic [WIDTH-1:0] res_numer_w;
    logic [WIDTH-1:0] res_denom_w;
    logic             res_ovf;
    logic [FIELD_W-1:0] res_numer_f;
    logic [FIELD_W-1:0] res_denom_f;

    assign nneg_in = n_w[WIDTH-1];
    assign dneg_in = d_w[WIDTH-1];
    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;
    assign a_gt_b  = a_reg > b_reg;

    // one restoring division step
    assign trial     = {rem_reg, quo_reg[WIDTH-1]};
    assign trial_sub = trial - {1'b0, dv_reg};

    assign neg = nneg_reg ^ dneg_reg;

    always_comb begin
        res_ovf = 1'b0;
        case (cmd.kind)
            KIND_UNDEF: begin
                res_numer_w = nneg_reg ? (~mag_n_reg + ONE_W) : mag_n_reg;
                res_denom_w = '0;
            end
            KIND_ZERO: begin
                res_numer_w = '0;
                res_denom_w = ONE_W;
            end
            default: begin
                res_numer_w = neg ? (~mn_reg + ONE_W) : mn_reg;
                res_denom_w = quo_reg;
                res_ovf     = (!neg && mn_reg == HALF) || (quo_reg == HALF);
            end
        endcase
    end

    // results zero-extended or truncated to the port width
    if (WIDTH < FIELD_W) begin : g_out_ext
        assign res_numer_f = {{(FIELD_W-WIDTH){1'b0}}, res_numer_w};
        assign res_denom_f = {{(FIELD_W-WIDTH){1'b0}}, res_denom_w};
    end else begin : g_out_cut
        assign res_numer_f = res_numer_w[FIELD_W-1:0];
        assign res_denom_f = res_denom_w[FIELD_W-1:0];
    end

    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        sh_next     = sh_reg;
        mag_n_next  = mag_n_reg;
        mag_d_next  = mag_d_reg;
        nneg_next   = nneg_reg;
        dneg_next   = dneg_reg;
        n_zero_next = n_zero_reg;
        d_zero_next = d_zero_reg;
        dv_next     = dv_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        mn_next     = mn_reg;
        out_numer_next = out_numer_reg;
        out_denom_next = out_denom_reg;
        out_undef_next = out_undef_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (cmd.op)
            OP_LOAD: begin
                mag_n_next  = nneg_in ? (~n_w + ONE_W) : n_w;
                mag_d_next  = dneg_in ? (~d_w + ONE_W) : d_w;
                a_next      = mag_n_next;
                b_next      = mag_d_next;
                sh_next     = '0;
                nneg_next   = nneg_in;
                dneg_next   = dneg_in;
                n_zero_next = (n_w == '0);
                d_zero_next = (d_w == '0);
            end
            OP_HALVE_BOTH: begin
                a_next  = a_reg >> 1;
                b_next  = b_reg >> 1;
                sh_next = sh_reg + SW'(1);
            end
            OP_HALVE_A: begin
                a_next = a_reg >> 1;
            end
            OP_GCD: begin
                if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_gt_b) begin
                    a_next = b_reg;
                    b_next = diff_ab;
                end else begin
                    b_next = diff_ba;
                end
            end
            OP_DIV_INIT_N: begin
                dv_next  = a_reg << sh_reg;
                rem_next = '0;
                quo_next = mag_n_reg;
                cnt_next = CW'(WIDTH);
            end
            OP_DIV_INIT_D: begin
                mn_next  = quo_reg;
                rem_next = '0;
                quo_next = mag_d_reg;
                cnt_next = CW'(WIDTH);
            end
            OP_DIV_STEP: begin
                if (!trial_sub[WIDTH]) begin
                    rem_next = trial_sub[WIDTH-1:0];
                    quo_next = {quo_reg[WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = trial[WIDTH-1:0];
                    quo_next = {quo_reg[WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
            end
            OP_EMIT: begin
                out_valid_next = 1'b1;
                out_numer_next = res_numer_f;
                out_denom_next = res_denom_f;
                out_undef_next = (cmd.kind == KIND_UNDEF);
                out_ovf_next   = res_ovf;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        sh_reg        <= sh_next;
        mag_n_reg     <= mag_n_next;
        mag_d_reg     <= mag_d_next;
        nneg_reg      <= nneg_next;
        dneg_reg      <= dneg_next;
        n_zero_reg    <= n_zero_next;
        d_zero_reg    <= d_zero_next;
        dv_reg        <= dv_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        mn_reg        <= mn_next;
        out_numer_reg <= out_numer_next;
        out_denom_reg <= out_denom_next;
        out_undef_reg <= out_undef_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign status.n_zero    = n_zero_reg;
    assign status.d_zero    = d_zero_reg;
    assign status.both_even = !a_reg[0] && !b_reg[0];
    assign status.a_even    = !a_reg[0];
    assign status.b_zero    = (b_reg == '0);
    // all WIDTH division steps are done
    assign status.div_last  = (cnt_reg == '0);
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid          = out_valid_reg;
    assign m_numer_out      = out_numer_reg;
    assign m_denom_out      = out_denom_reg;
    assign m_undefined_flag = out_undef_reg;
    assign m_overflow_flag  = out_ovf_reg;

endmodule

// File: hw/rtl/rational_reduce_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_reduce_core
// Reduces a signed fraction to lowest terms with the sign on the numerator.
//
// Input beat: s_numer_in / s_denom_in on s_valid / s_ready. Result beat:
// m_numer_out, m_denom_out, m_undefined_flag, m_overflow_flag on
// m_valid / m_ready. One item is worked at a time; s_ready is high only
// while the sequencer is idle.
// For a zero denominator or zero numerator the sequencer goes straight from
// classification to the result write. Otherwise the binary gcd runs one
// shift or subtract per cycle, its step count set by the operand bit
// patterns, then the shared restoring divider divides the numerator and
// then the denominator magnitude by the gcd.
// The result sits in an output register; while the receiver stalls the
// next item is still accepted and worked, and it waits only at the final
// write into that register. Reset empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_reduce_core
    import rr_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [FIELD_W-1:0] s_numer_in,
    input  logic signed [FIELD_W-1:0] s_denom_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [FIELD_W-1:0] m_numer_out,
    output logic signed [FIELD_W-1:0] m_denom_out,
    output logic                      m_undefined_flag,
    output logic                      m_overflow_flag
);

    cmd_t    cmd;
    status_t status;

    rr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rr_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_numer_in       (s_numer_in),
        .s_denom_in       (s_denom_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_numer_out      (m_numer_out),
        .m_denom_out      (m_denom_out),
        .m_undefined_flag (m_undefined_flag),
        .m_overflow_flag  (m_overflow_flag)
    );

endmodule
